FILE: rtl/core/primary_ray_direction_defines.svh
// Assertion macros for the primary ray direction block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef PRIMARY_RAY_DIRECTION_DEFINES_SVH
`define PRIMARY_RAY_DIRECTION_DEFINES_SVH

// check a condition at every clock edge out of reset
`define PRD_ASSERT(label, expr) \
label: assert property (@(posedge clk) disable iff (!rst_n) expr) \
    else $error("primary_ray_direction: check failed");

// check a condition in the cycle after a trigger
`define PRD_ASSERT_NEXT(label, cond, expr) \
label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> expr) \
    else $error("primary_ray_direction: check failed");

`endif

FILE: rtl/core/prd_pkg.sv
// Shared types, widths and helpers for the primary ray direction block.
// No dependencies.
package prd_pkg;

    localparam int NdcW   = 16;
    localparam int DirW   = 16;
    localparam int ScaleW = 16;
    localparam int BasisW = 48;
    localparam int DataW  = 64;
    localparam int AddrW  = 6;
    localparam int MagW   = 30;
    localparam int Len2W  = 62;
    localparam int LenW   = 31;

    typedef enum logic [2:0] {
        REG_RIGHT   = 3'd0,
        REG_UP      = 3'd1,
        REG_FWD     = 3'd2,
        REG_SCALE_X = 3'd3,
        REG_SCALE_Y = 3'd4
    } prd_reg_idx_t;

    typedef struct packed {
        logic [BasisW-1:0] right;
        logic [BasisW-1:0] up;
        logic [BasisW-1:0] fwd;
        logic [ScaleW-1:0] scale_x;
        logic [ScaleW-1:0] scale_y;
    } prd_cfg_t;

    typedef struct packed {
        logic                     zero;
        logic [2:0]               neg;
        logic [2:0][MagW-1:0]     mag;
    } prd_vec_t;

    function automatic logic signed [15:0] lane(input logic [BasisW-1:0] vec,
                                                input logic [1:0] idx);
        logic [15:0] sel;
        unique case (idx)
            2'd0:    sel = vec[47:32];
            2'd1:    sel = vec[31:16];
            default: sel = vec[15:0];
        endcase
        return $signed(sel);
    endfunction

endpackage

FILE: rtl/core/prd_if.sv
// Valid/ready channel interfaces for NDC input words and direction output words.
// Depends on prd_pkg.
interface prd_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [prd_pkg::NdcW-1:0]  ndc_x;
    logic signed [prd_pkg::NdcW-1:0]  ndc_y;

    modport source (output valid, ndc_x, ndc_y, input ready);
    modport sink   (input valid, ndc_x, ndc_y, output ready);
endinterface

interface prd_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [prd_pkg::DirW-1:0]  dir_x;
    logic signed [prd_pkg::DirW-1:0]  dir_y;
    logic signed [prd_pkg::DirW-1:0]  dir_z;

    modport source (output valid, dir_x, dir_y, dir_z, input ready);
    modport sink   (input valid, dir_x, dir_y, dir_z, output ready);
endinterface

FILE: rtl/core/prd_regs.sv
// APB configuration registers: camera basis vectors and NDC scales.
// Depends on prd_pkg.
module prd_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [prd_pkg::AddrW-1:0]    paddr,
    input  logic [prd_pkg::DataW-1:0]    pwdata,
    output logic [prd_pkg::DataW-1:0]    prdata,
    output logic                         pready,
    output prd_pkg::prd_cfg_t            cfg
);

    prd_pkg::prd_cfg_t     cfg_reg;
    prd_pkg::prd_cfg_t     cfg_next;
    prd_pkg::prd_reg_idx_t idx;
    logic                  wr;

    assign idx    = prd_pkg::prd_reg_idx_t'(paddr[5:3]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (idx)
                prd_pkg::REG_RIGHT:   cfg_next.right   = pwdata[47:0];
                prd_pkg::REG_UP:      cfg_next.up      = pwdata[47:0];
                prd_pkg::REG_FWD:     cfg_next.fwd     = pwdata[47:0];
                prd_pkg::REG_SCALE_X: cfg_next.scale_x = pwdata[15:0];
                prd_pkg::REG_SCALE_Y: cfg_next.scale_y = pwdata[15:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            prd_pkg::REG_RIGHT:   prdata = {16'd0, cfg_reg.right};
            prd_pkg::REG_UP:      prdata = {16'd0, cfg_reg.up};
            prd_pkg::REG_FWD:     prdata = {16'd0, cfg_reg.fwd};
            prd_pkg::REG_SCALE_X: prdata = {48'd0, cfg_reg.scale_x};
            prd_pkg::REG_SCALE_Y: prdata = {48'd0, cfg_reg.scale_y};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.right   <= 48'h8000_0000_0000;
            cfg_reg.up      <= 48'h0000_7FFF_0000;
            cfg_reg.fwd     <= 48'h0000_0000_7FFF;
            cfg_reg.scale_x <= 16'd3016;
            cfg_reg.scale_y <= 16'd1697;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/core/prd_front.sv
// Front pipeline: NDC scaling, basis mix, magnitude, block alignment, squared length.
// Eight register stages. Depends on prd_pkg.
module prd_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic signed [prd_pkg::NdcW-1:0]  ndc_x,
    input  logic signed [prd_pkg::NdcW-1:0]  ndc_y,
    input  prd_pkg::prd_cfg_t                cfg,
    output logic                             out_valid,
    output prd_pkg::prd_vec_t                out_vec,
    output logic [prd_pkg::Len2W-1:0]        out_len2
);

    logic [7:0]               vld_reg;
    logic signed [32:0]       cx_reg, cy_reg, cx_next, cy_next;
    logic signed [48:0]       pr_reg [3];
    logic signed [48:0]       pu_reg [3];
    logic signed [48:0]       pr_next [3];
    logic signed [48:0]       pu_next [3];
    logic signed [42:0]       pf_reg [3];
    logic signed [42:0]       pf_next [3];
    logic signed [49:0]       v_reg [3];
    logic signed [49:0]       v_next [3];
    logic signed [49:0]       absv [3];
    logic [2:0]               neg4_reg, neg4_next, neg5_reg;
    logic [47:0]              mag4_reg [3];
    logic [47:0]              mag4_next [3];
    logic [47:0]              mag5_reg [3];
    logic [47:0]              orv;
    logic [47:0]              shv [3];
    logic [5:0]               lead5_reg, lead5_next;
    logic                     zero5_reg, zero5_next;
    prd_pkg::prd_vec_t        vec6_reg, vec6_next, vec7_reg, vec8_reg;
    logic [59:0]              sq7_reg [3];
    logic [59:0]              sq7_next [3];
    logic [prd_pkg::Len2W-1:0] len2_reg, len2_next;

    always_comb
    begin
        cx_next = ndc_x * $signed({1'b0, cfg.scale_x});
        cy_next = ndc_y * $signed({1'b0, cfg.scale_y});
        for (int i = 0; i < 3; i++)
        begin
            pr_next[i] = prd_pkg::lane(cfg.right, 2'(i)) * cx_reg;
            pu_next[i] = prd_pkg::lane(cfg.up, 2'(i)) * cy_reg;
            pf_next[i] = {prd_pkg::lane(cfg.fwd, 2'(i)), 27'd0};
            v_next[i]  = pr_reg[i] + pu_reg[i] + pf_reg[i];
            neg4_next[i] = v_reg[i][49];
            absv[i]      = v_reg[i][49] ? -v_reg[i] : v_reg[i];
            mag4_next[i] = absv[i][47:0];
        end
    end

    // top bit of the OR equals top bit of the largest magnitude
    always_comb
    begin
        orv        = mag4_reg[0] | mag4_reg[1] | mag4_reg[2];
        zero5_next = (orv == '0);
        lead5_next = '0;
        for (int j = 0; j < 48; j++)
        begin
            if (orv[j])
            begin
                lead5_next = 6'(j);
            end
        end
    end

    always_comb
    begin
        vec6_next.zero = zero5_reg;
        vec6_next.neg  = neg5_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (lead5_reg > 6'd29)
            begin
                shv[i] = mag5_reg[i] >> (lead5_reg - 6'd29);
            end
            else
            begin
                shv[i] = mag5_reg[i] << (6'd29 - lead5_reg);
            end
            vec6_next.mag[i] = shv[i][29:0];
            sq7_next[i]      = vec6_reg.mag[i] * vec6_reg.mag[i];
        end
        len2_next = 62'(sq7_reg[0]) + 62'(sq7_reg[1]) + 62'(sq7_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[6:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            pr_reg    <= pr_next;
            pu_reg    <= pu_next;
            pf_reg    <= pf_next;
            v_reg     <= v_next;
            neg4_reg  <= neg4_next;
            mag4_reg  <= mag4_next;
            neg5_reg  <= neg4_reg;
            mag5_reg  <= mag4_reg;
            lead5_reg <= lead5_next;
            zero5_reg <= zero5_next;
            vec6_reg  <= vec6_next;
            vec7_reg  <= vec6_reg;
            sq7_reg   <= sq7_next;
            vec8_reg  <= vec7_reg;
            len2_reg  <= len2_next;
        end
    end

    assign out_valid = vld_reg[7];
    assign out_vec   = vec8_reg;
    assign out_len2  = len2_reg;

endmodule

FILE: rtl/core/prd_isqrt.sv
// Pipelined integer square root, one result bit per stage, 32 stages.
// Depends on prd_pkg.
module prd_isqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  prd_pkg::prd_vec_t          in_vec,
    input  logic [prd_pkg::Len2W-1:0]  in_len2,
    output logic                       out_valid,
    output prd_pkg::prd_vec_t          out_vec,
    output logic [prd_pkg::LenW-1:0]   out_len
);

    logic [31:0]        vld_reg;
    prd_pkg::prd_vec_t  vec_reg [32];
    logic [63:0]        n_reg [32];
    logic [63:0]        res_reg [32];
    logic [63:0]        n_next [32];
    logic [63:0]        res_next [32];
    logic [63:0]        n_src [32];
    logic [63:0]        res_src [32];

    always_comb
    begin
        logic [63:0] bitv;
        logic [63:0] t;
        n_src[0]   = 64'(in_len2);
        res_src[0] = '0;
        for (int j = 1; j < 32; j++)
        begin
            n_src[j]   = n_reg[j-1];
            res_src[j] = res_reg[j-1];
        end
        for (int j = 0; j < 32; j++)
        begin
            bitv = 64'd1 << (2 * (31 - j));
            t    = res_src[j] + bitv;
            if (n_src[j] >= t)
            begin
                n_next[j]   = n_src[j] - t;
                res_next[j] = (res_src[j] >> 1) + bitv;
            end
            else
            begin
                n_next[j]   = n_src[j];
                res_next[j] = res_src[j] >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[30:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_reg[0] <= in_vec;
            for (int j = 1; j < 32; j++)
            begin
                vec_reg[j] <= vec_reg[j-1];
            end
            n_reg   <= n_next;
            res_reg <= res_next;
        end
    end

    assign out_valid = vld_reg[31];
    assign out_vec   = vec_reg[31];
    assign out_len   = res_reg[31][30:0];

endmodule

FILE: rtl/core/prd_div.sv
// Pipelined rounding divide of each aligned magnitude by the length, then sign and saturate.
// 18 register stages. Depends on prd_pkg.
module prd_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  prd_pkg::prd_vec_t                in_vec,
    input  logic [prd_pkg::LenW-1:0]         in_len,
    output logic                             out_valid,
    output logic [2:0][prd_pkg::DirW-1:0]    out_dir
);

    logic [17:0]                  vld_reg;
    logic [prd_pkg::LenW-1:0]     len_reg [17];
    logic [2:0]                   neg_reg [17];
    logic                         zero_reg [17];
    logic [2:0][46:0]             rem_reg [17];
    logic [2:0][46:0]             rem_next [17];
    logic [2:0][15:0]             q_reg [17];
    logic [2:0][15:0]             q_next [17];
    logic [2:0][15:0]             dir_reg, dir_next;

    always_comb
    begin
        logic [46:0] d;
        for (int i = 0; i < 3; i++)
        begin
            rem_next[0][i] = 47'({in_vec.mag[i], 15'd0}) + 47'(in_len >> 1);
            q_next[0][i]   = '0;
        end
        for (int j = 1; j < 17; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d = 47'(len_reg[j-1]) << (16 - j);
                if (rem_reg[j-1][i] >= d)
                begin
                    rem_next[j][i] = rem_reg[j-1][i] - d;
                    q_next[j][i]   = q_reg[j-1][i] | (16'd1 << (16 - j));
                end
                else
                begin
                    rem_next[j][i] = rem_reg[j-1][i];
                    q_next[j][i]   = q_reg[j-1][i];
                end
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            if (zero_reg[16])
            begin
                dir_next[i] = '0;
            end
            else if (neg_reg[16][i])
            begin
                dir_next[i] = 16'd0 - q_reg[16][i];
            end
            else if (q_reg[16][i][15])
            begin
                dir_next[i] = 16'h7FFF;
            end
            else
            begin
                dir_next[i] = q_reg[16][i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[16:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len_reg[0]  <= in_len;
            neg_reg[0]  <= in_vec.neg;
            zero_reg[0] <= in_vec.zero;
            for (int j = 1; j < 17; j++)
            begin
                len_reg[j]  <= len_reg[j-1];
                neg_reg[j]  <= neg_reg[j-1];
                zero_reg[j] <= zero_reg[j-1];
            end
            rem_reg <= rem_next;
            q_reg   <= q_next;
            dir_reg <= dir_next;
        end
    end

    assign out_valid = vld_reg[17];
    assign out_dir   = dir_reg;

endmodule

FILE: rtl/core/primary_ray_direction.sv
// Primary ray direction: NDC pair in, unit world-space ray direction out.
// Channels: ndc (valid/ready, ndc_x/ndc_y signed Q1.15) and dir (valid/ready,
// dir_x/dir_y/dir_z signed Q1.15). Camera basis and scales sit on an APB port,
// 64-bit data, register i at byte address 8*i; write only while idle.
// Throughput: one word per cycle, fully pipelined, while the buffer has room.
// Pipeline: 8 front stages, 32 square-root stages (one root bit each) and 18
// divide stages, then an output buffer that drives dir.
// A two-word output buffer takes the pipeline's results; the whole pipeline
// holds while that buffer is full, and ndc.ready is low only then. A stall on
// dir loses and repeats nothing.
// Reset: all valid bits and the buffer clear; registers return to the camera
// looking down +z with right (-1,0,0), up (0,1,0) and the default scales.
// Depends on prd_pkg, prd_if, prd_regs, prd_front, prd_isqrt, prd_div.
`include "primary_ray_direction_defines.svh"

module primary_ray_direction (
    input  logic                         clk,
    input  logic                         rst_n,
    prd_in_if.sink                       ndc,
    prd_out_if.source                    dir,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [prd_pkg::AddrW-1:0]    paddr,
    input  logic [prd_pkg::DataW-1:0]    pwdata,
    output logic [prd_pkg::DataW-1:0]    prdata,
    output logic                         pready
);

    prd_pkg::prd_cfg_t                cfg;
    logic                             en;
    logic                             fr_valid, sq_valid, dv_valid;
    prd_pkg::prd_vec_t                fr_vec, sq_vec;
    logic [prd_pkg::Len2W-1:0]        fr_len2;
    logic [prd_pkg::LenW-1:0]         sq_len;
    logic [2:0][prd_pkg::DirW-1:0]    dv_dir;
    logic [2:0][prd_pkg::DirW-1:0]    fifo_reg [2];
    logic [1:0]                       count_reg, count_next;
    logic                             wr_ptr_reg, rd_ptr_reg;
    logic                             push, pop;

    prd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    prd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ndc.valid),
        .ndc_x     (ndc.ndc_x),
        .ndc_y     (ndc.ndc_y),
        .cfg       (cfg),
        .out_valid (fr_valid),
        .out_vec   (fr_vec),
        .out_len2  (fr_len2)
    );

    prd_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_vec    (fr_vec),
        .in_len2   (fr_len2),
        .out_valid (sq_valid),
        .out_vec   (sq_vec),
        .out_len   (sq_len)
    );

    prd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_vec    (sq_vec),
        .in_len    (sq_len),
        .out_valid (dv_valid),
        .out_dir   (dv_dir)
    );

    assign en        = (count_reg != 2'd2);
    assign push      = en && dv_valid;
    assign pop       = dir.valid && dir.ready;
    assign ndc.ready = en;
    assign dir.valid = (count_reg != 2'd0);
    assign dir.dir_x = fifo_reg[rd_ptr_reg][0];
    assign dir.dir_y = fifo_reg[rd_ptr_reg][1];
    assign dir.dir_z = fifo_reg[rd_ptr_reg][2];
    assign count_next = 2'(count_reg + {1'b0, push} - {1'b0, pop});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= dv_dir;
        end
    end

    `PRD_ASSERT(a_count_range, count_reg != 2'd3)
    `PRD_ASSERT(a_stall_has_word, (!ndc.ready |-> dir.valid))
    `PRD_ASSERT_NEXT(a_drain, (pop && !push), (count_reg == $past(count_reg) - 2'd1))
    `PRD_ASSERT_NEXT(a_fill, (push && !pop), (count_reg == $past(count_reg) + 2'd1))

endmodule
